// ----- rtl/fhl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the fire hotspot line generator.
// Used by fhl_cell and fire_hotspot_line_generator; depends on nothing.
package fhl_pkg;

	// Defaults for the top level parameters.
	localparam int HOTSPOT_COUNT_DEF  = 48;
	localparam int MAX_LINE_WIDTH_DEF = 1024;

	// Field widths.
	localparam int REQ_W   = 2;
	localparam int IDX_W   = 6;
	localparam int POS_W   = 10;
	localparam int STEP_W  = 3;
	localparam int LWID_W  = 11;
	localparam int HEAT_W  = 8;
	// Wide enough to name any cell of the largest chain.
	localparam int CELL_ID_W = 8;
	// Signed working width for position arithmetic.
	localparam int ARITH_W = 13;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_MOVE   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	localparam logic [LWID_W-1:0]         WIDTH_RESET = 11'd320;
	localparam logic signed [ARITH_W-1:0] HEAT_RADIUS = 13'sd20;
	localparam logic [HEAT_W:0]           HEAT_MAX    = 9'd192;
	localparam logic signed [ARITH_W-1:0] STEP_BIAS   = 13'sd3;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [IDX_W-1:0]  spot_index;
		logic [POS_W-1:0]  load_position;
		logic [STEP_W-1:0] random_step;
		logic [POS_W-1:0]  column;
	} req_t;

	typedef struct packed {
		logic [HEAT_W-1:0] intensity;
		logic [POS_W-1:0]  spot_position;
	} rsp_t;

	// Word that travels down the cell chain.
	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [IDX_W-1:0]  spot_index;
		logic [POS_W-1:0]  load_position;
		logic [STEP_W-1:0] random_step;
		logic [POS_W-1:0]  column;
		logic [LWID_W-1:0] width;
		logic              live;
		logic [HEAT_W-1:0] heat;
		logic [POS_W-1:0]  position;
	} item_t;

endpackage

// ----- rtl/fire_hotspot_line_generator.sv -----
`timescale 1ns / 1ps
// Top level of the fire hotspot line generator: launch register, width
// register and a chain of fhl_cell instances. Depends on fhl_pkg, fhl_cell.
//
// Usage: a request word (load, move or query) is taken at a rising edge at
// which start is high and busy is low. The word is launched into a chain of
// HOTSPOT_COUNT cells, one cell per hotspot. Each cell keeps one hotspot
// position; on a load or move the addressed cell updates its position and
// writes it into the word, and on a query every cell near the column adds
// its heat term to the running saturated sum as the word passes by.
// The result word appears on result for exactly one cycle, flagged by done,
// after the word has passed the launch register and then the register of
// each cell in turn. The receiver cannot stall the block, so nothing is
// held back on the output side.
// Only one request is in the chain at a time; a new start is taken in the
// cycle in which done is shown.
// The configuration channel (cfg_valid / cfg_ready / cfg_data) writes the
// line width and is always ready; the user must write it only while the
// block is idle, and the block itself does not enforce this. Reset sets
// the width to 320 and all hotspot positions to zero.
module fire_hotspot_line_generator #(
	parameter int HOTSPOT_COUNT  = fhl_pkg::HOTSPOT_COUNT_DEF,
	parameter int MAX_LINE_WIDTH = fhl_pkg::MAX_LINE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  fhl_pkg::req_t               req,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [fhl_pkg::LWID_W-1:0]  cfg_data,
	output logic                        done,
	output fhl_pkg::rsp_t               result
);

	localparam logic [fhl_pkg::ARITH_W-1:0] MAX_W = fhl_pkg::ARITH_W'(MAX_LINE_WIDTH);

	logic [fhl_pkg::LWID_W-1:0] line_width_q;
	logic                       busy_q;
	logic                       launch_valid_q;
	fhl_pkg::item_t             launch_item_q;

	logic [fhl_pkg::LWID_W-1:0] eff_width;
	logic                       accept;
	fhl_pkg::item_t             launch_item;

	// Chain links: entry 0 is the launch register, the last one the output.
	logic           chain_valid [HOTSPOT_COUNT+1];
	fhl_pkg::item_t chain_item  [HOTSPOT_COUNT+1];

	assign cfg_ready = 1'b1;
	assign busy      = busy_q && !done;
	assign accept    = start && !busy;

	// The width in use is the register saturated into 1 .. MAX_LINE_WIDTH.
	always_comb begin
		if (line_width_q == '0) begin
			eff_width = 11'd1;
		end else if ({2'b00, line_width_q} > MAX_W) begin
			eff_width = MAX_W[fhl_pkg::LWID_W-1:0];
		end else begin
			eff_width = line_width_q;
		end

		launch_item.req_type      = req.req_type;
		launch_item.spot_index    = req.spot_index;
		launch_item.load_position = req.load_position;
		launch_item.random_step   = req.random_step;
		launch_item.column        = req.column;
		launch_item.width         = eff_width;
		// A query off the end of the line collects no heat at all.
		launch_item.live          = ({1'b0, req.column} < eff_width);
		launch_item.heat          = '0;
		launch_item.position      = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= fhl_pkg::WIDTH_RESET;
			busy_q         <= 1'b0;
			launch_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				line_width_q <= cfg_data;
			end
			launch_valid_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			launch_item_q <= launch_item;
		end
	end

	assign chain_valid[0] = launch_valid_q;
	assign chain_item[0]  = launch_item_q;

	for (genvar k = 0; k < HOTSPOT_COUNT; k++) begin : g_cell
		fhl_cell #(
			.CELL_INDEX(k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (chain_valid[k]),
			.in_item  (chain_item[k]),
			.out_valid(chain_valid[k+1]),
			.out_item (chain_item[k+1])
		);
	end

	// The word leaving the last cell is the result; it shows for one cycle.
	assign done                 = chain_valid[HOTSPOT_COUNT];
	assign result.intensity     = chain_item[HOTSPOT_COUNT].heat;
	assign result.spot_position = chain_item[HOTSPOT_COUNT].position;

endmodule

// ----- rtl/fhl_cell.sv -----
`timescale 1ns / 1ps
// One cell of the hotspot chain: holds one hotspot position, updates it on
// a load or move and adds its heat to a passing query. Depends on fhl_pkg.
module fhl_cell #(
	parameter int CELL_INDEX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  fhl_pkg::item_t in_item,
	output logic          out_valid,
	output fhl_pkg::item_t out_item
);

	localparam logic [fhl_pkg::CELL_ID_W-1:0] CELL_ID = fhl_pkg::CELL_ID_W'(CELL_INDEX);

	logic [fhl_pkg::POS_W-1:0] pos_q;
	logic                      out_valid_q;
	fhl_pkg::item_t            out_item_q;

	logic                                 hit;
	logic [fhl_pkg::LWID_W-1:0]           load_pos;
	logic signed [fhl_pkg::ARITH_W-1:0]   w_s, ps, ps_wrap, ps_sat, col_delta, adist;
	logic [fhl_pkg::POS_W-1:0]            new_pos;
	logic [fhl_pkg::HEAT_W:0]             heat_sum;
	logic [fhl_pkg::HEAT_W-1:0]           term;
	logic                                 in_span;
	fhl_pkg::item_t                       next_item;

	always_comb begin
		hit = in_valid
			&& ({{(fhl_pkg::CELL_ID_W-fhl_pkg::IDX_W){1'b0}}, in_item.spot_index} == CELL_ID)
			&& (in_item.req_type == fhl_pkg::REQ_LOAD || in_item.req_type == fhl_pkg::REQ_MOVE);

		// A load beyond the line lands on its last column.
		if ({1'b0, in_item.load_position} >= in_item.width) begin
			load_pos = in_item.width - 11'd1;
		end else begin
			load_pos = {1'b0, in_item.load_position};
		end

		// A move wraps once, then saturates anything still off the line.
		w_s = $signed({2'b00, in_item.width});
		ps  = $signed({3'b000, pos_q}) + $signed({10'b0, in_item.random_step})
			- fhl_pkg::STEP_BIAS;
		if (ps < 0) begin
			ps_wrap = ps + w_s;
		end else if (ps >= w_s) begin
			ps_wrap = ps - w_s;
		end else begin
			ps_wrap = ps;
		end
		if (ps_wrap < 0) begin
			ps_sat = '0;
		end else if (ps_wrap >= w_s) begin
			ps_sat = w_s - 13'sd1;
		end else begin
			ps_sat = ps_wrap;
		end

		if (in_item.req_type == fhl_pkg::REQ_LOAD) begin
			new_pos = load_pos[fhl_pkg::POS_W-1:0];
		end else begin
			new_pos = ps_sat[fhl_pkg::POS_W-1:0];
		end

		// Heat term of this hotspot at the queried column.
		col_delta = $signed({3'b000, in_item.column}) - $signed({3'b000, pos_q});
		adist     = (col_delta < 0) ? -col_delta : col_delta;
		in_span   = (col_delta >= -fhl_pkg::HEAT_RADIUS) && (col_delta < fhl_pkg::HEAT_RADIUS);
		term      = fhl_pkg::HEAT_W'(fhl_pkg::HEAT_RADIUS - adist);
		heat_sum  = {1'b0, in_item.heat} + {1'b0, term};

		next_item = in_item;
		if (hit) begin
			next_item.position = new_pos;
		end
		if (in_item.req_type == fhl_pkg::REQ_QUERY && in_item.live && in_span) begin
			if (heat_sum > fhl_pkg::HEAT_MAX) begin
				next_item.heat = fhl_pkg::HEAT_MAX[fhl_pkg::HEAT_W-1:0];
			end else begin
				next_item.heat = heat_sum[fhl_pkg::HEAT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= in_valid;
			if (hit) begin
				pos_q <= new_pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		out_item_q <= next_item;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
